@@ design/v2r_pkg.sv @@
// ----------------------------------------------------------------------------
// v2r_pkg: shared types and helpers for the VRAM to RGB565 repacker
// Holds byte-holder state, result struct and pixel format conversions.
// ----------------------------------------------------------------------------
package v2r_pkg;

	localparam logic [1:0] HOLD_EMPTY = 2'd0;
	localparam logic [1:0] HOLD_ONE   = 2'd1;
	localparam logic [1:0] HOLD_TWO   = 2'd2;

	typedef struct packed {
		logic [15:0] bytes;
		logic [1:0]  count;
	} holder_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] pixel;
		logic        last;
	} result_t;

	function automatic logic [15:0] from_bgr555(input logic [15:0] v);
		from_bgr555 = {v[4:0], v[9:5], 1'b0, v[14:10]};
	endfunction

	function automatic logic [15:0] from_rgb888(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		from_rgb888 = {r[7:3], g[7:2], b[7:3]};
	endfunction

endpackage

@@ design/v2r_convert.sv @@
// ----------------------------------------------------------------------------
// v2r_convert: per-word conversion logic
// Computes the pixel for one word and the next byte-holder state.
// ----------------------------------------------------------------------------
module v2r_convert (
	input  logic             mode24,
	input  logic [15:0]      word,
	input  logic             last,
	input  v2r_pkg::holder_t cur,
	output v2r_pkg::holder_t nxt,
	output v2r_pkg::result_t res
);

	logic [7:0] lo;
	logic [7:0] hi;

	assign lo = word[7:0];
	assign hi = word[15:8];

	always_comb begin
		nxt = '{bytes: 16'h0000, count: v2r_pkg::HOLD_EMPTY};
		res = '{valid: 1'b0, pixel: 16'h0000, last: last};
		if (!mode24) begin
			res.valid = 1'b1;
			res.pixel = v2r_pkg::from_bgr555(word);
		end else begin
			case (cur.count)
				v2r_pkg::HOLD_TWO: begin
					res.valid = 1'b1;
					res.pixel = v2r_pkg::from_rgb888(cur.bytes[7:0], cur.bytes[15:8], lo);
					if (!last) begin
						nxt.bytes = {8'h00, hi};
						nxt.count = v2r_pkg::HOLD_ONE;
					end
				end
				v2r_pkg::HOLD_ONE: begin
					res.valid = 1'b1;
					res.pixel = v2r_pkg::from_rgb888(cur.bytes[7:0], lo, hi);
				end
				default: begin
					// empty holder: keep the word unless the row ends here
					if (!last) begin
						nxt.bytes = word;
						nxt.count = v2r_pkg::HOLD_TWO;
					end
				end
			endcase
		end
	end

endmodule

@@ design/vram_to_rgb565_repacker.sv @@
// ----------------------------------------------------------------------------
// vram_to_rgb565_repacker: VRAM word stream to RGB565 pixel converter
// Registered output: a pixel is valid the cycle after its request is accepted.
// Throughput: 1 word per cycle unless the full output stalls; a request is taken while a result drains.
// Reset: mode returns to 15-bit, byte holder empties, output register empties.
// ----------------------------------------------------------------------------
module vram_to_rgb565_repacker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] vram_word,
	input  logic        row_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] pixel_rgb565,
	output logic        row_last
);

	logic             mode24_q;
	v2r_pkg::holder_t holder_q;
	v2r_pkg::holder_t holder_nxt;
	v2r_pkg::result_t res;
	logic             valid_s1;
	logic [15:0]      pixel_s1;
	logic             last_s1;
	logic             in_accept;

	assign in_stall  = valid_s1 && out_stall;
	assign in_accept = in_valid && !in_stall;

	v2r_convert u_convert (
		.mode24 (mode24_q),
		.word   (vram_word),
		.last   (row_end),
		.cur    (holder_q),
		.nxt    (holder_nxt),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode24_q <= 1'b0;
		end else if (cfg_we) begin
			mode24_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holder_q <= '{bytes: 16'h0000, count: v2r_pkg::HOLD_EMPTY};
		end else if (in_accept) begin
			holder_q <= holder_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= res.valid;
		end else if (!out_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	// hold payload while the result waits
	always_ff @(posedge clk) begin
		if (in_accept) begin
			pixel_s1 <= res.pixel;
			last_s1  <= res.last;
		end
	end

	assign out_valid    = valid_s1;
	assign pixel_rgb565 = pixel_s1;
	assign row_last     = last_s1;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_stall))
		else $error("request stalled with a free output register");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		holder_q.count != 2'd3)
		else $error("byte holder count out of range");

	a_bgr_empties_holder: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && !mode24_q) |=> (holder_q.count == v2r_pkg::HOLD_EMPTY && valid_s1))
		else $error("15-bit request did not empty holder or give a pixel");

	a_two_held_gives_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && mode24_q && holder_q.count == v2r_pkg::HOLD_TWO) |=> valid_s1)
		else $error("pixel missing after completing held bytes");

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: stream check of the VRAM word to RGB565 repacker
// Drives 15-bit and packed 24-bit word streams through the valid/stall ports,
// predicts every pixel and its row flag, and compares them in order. Runs
// directed rows, then random rows under several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
module testbench;

	localparam int HALF_PERIOD = 5;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_OFF_CYCLES = 300;

	typedef enum logic {MODE_BGR15 = 1'b0, MODE_RGB24 = 1'b1} mode_e;

	typedef struct packed {
		logic [15:0] data;
		logic        eor;
	} vram_req_t;

	typedef struct packed {
		logic [15:0] pixel;
		logic        last;
	} pixel_exp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] vram_word = 16'h0000;
	logic        row_end = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] pixel_rgb565;
	logic        row_last;

	vram_req_t  word_queue[$];
	pixel_exp_t pending_pixels[$];

	mode_e            cur_mode = MODE_BGR15;
	v2r_pkg::holder_t byte_holder = '0;

	bit req_taken = 1'b0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_len = 0;
	int errors = 0;
	int cycles = 0;

	vram_to_rgb565_repacker DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.vram_word(vram_word),
		.row_end(row_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_rgb565(pixel_rgb565),
		.row_last(row_last)
	);

	always #(HALF_PERIOD) clk = ~clk;

	function automatic logic [15:0] bgr555_to_565(input logic [15:0] w);
		logic [15:0] r, g, b;
		r = w & 16'h001f;
		g = (w & 16'h03e0) >> 5;
		b = (w >> 10) & 16'h001f;
		return (r << 11) | (g << 6) | b;
	endfunction

	function automatic logic [15:0] rgb888_to_565(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		logic [15:0] r16, g16, b16;
		r16 = 16'(r) >> 3;
		g16 = 16'(g) >> 2;
		b16 = 16'(b) >> 3;
		return (r16 << 11) | (g16 << 5) | b16;
	endfunction

	function automatic void expect_pixel(input logic [15:0] p, input logic re);
		pixel_exp_t e;
		e.pixel = p;
		e.last = re;
		pending_pixels.push_back(e);
	endfunction

	function automatic void convert_word(input logic [15:0] w, input logic re);
		logic [7:0] lo, hi;
		lo = w[7:0];
		hi = w[15:8];
		if (cur_mode == MODE_BGR15) begin
			byte_holder = '0;
			expect_pixel(bgr555_to_565(w), re);
		end else begin
			case (byte_holder.count)
				v2r_pkg::HOLD_TWO: begin
					expect_pixel(rgb888_to_565(byte_holder.bytes[7:0],
						byte_holder.bytes[15:8], lo), re);
					if (re) begin
						byte_holder = '0;
					end else begin
						byte_holder.bytes = {8'h00, hi};
						byte_holder.count = v2r_pkg::HOLD_ONE;
					end
				end
				v2r_pkg::HOLD_ONE: begin
					expect_pixel(rgb888_to_565(byte_holder.bytes[7:0], lo, hi), re);
					byte_holder = '0;
				end
				default: begin
					if (re) begin
						byte_holder = '0;
					end else begin
						byte_holder.bytes = w;
						byte_holder.count = v2r_pkg::HOLD_TWO;
					end
				end
			endcase
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
		input logic [15:0] want);
		$display("mismatch at cycle %0d: %s got %h expected %h", cycles, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		pixel_exp_t e;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECK FAILED");
			$finish;
		end else if (arst_n) begin
			req_taken = in_valid && !in_stall;
			if (req_taken)
				convert_word(vram_word, row_end);
			if (out_valid && !out_stall) begin
				if (pending_pixels.size() == 0) begin
					report_mismatch("unexpected pixel", pixel_rgb565, 16'h0000);
				end else begin
					e = pending_pixels.pop_front();
					if (pixel_rgb565 !== e.pixel)
						report_mismatch("pixel_rgb565", pixel_rgb565, e.pixel);
					if (row_last !== e.last)
						report_mismatch("row_last", 16'(row_last), 16'(e.last));
				end
			end
		end else begin
			req_taken = 1'b0;
		end
	end

	always @(negedge clk) begin
		vram_req_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || req_taken) begin
			if (word_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				r = word_queue.pop_front();
				in_valid <= 1'b1;
				vram_word <= r.data;
				row_end <= r.eor;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_len > 0) begin
			out_stall <= 1'b1;
			hold_len--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic write_mode(input mode_e m);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		cur_mode = m;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (word_queue.size() != 0 || in_valid || pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic begin_phase(input mode_e m, input int send_pct, input int recv_pct);
		write_mode(m);
		@(posedge clk);
		send_idle_pct = send_pct;
		stall_pct = recv_pct;
	endtask

	task automatic push_word(input logic [15:0] w, input logic re);
		vram_req_t r;
		r.data = w;
		r.eor = re;
		word_queue.push_back(r);
	endtask

	task automatic push_random_rows(input int target);
		int added;
		int n;
		int sel;
		logic noise_end;
		added = 0;
		while (added < target) begin
			sel = $urandom_range(99);
			noise_end = 1'b1;
			if (sel < 80) begin
				n = $urandom_range(1, 24);
				if (n % 3 == 1)
					n++;
			end else if (sel < 92) begin
				n = 3 * $urandom_range(0, 7) + 1;
			end else begin
				n = 1;
				noise_end = 1'($urandom_range(1));
			end
			for (int i = 0; i < n; i++)
				push_word(16'($urandom_range(16'hffff)), (i == n - 1) ? noise_end : 1'b0);
			added += n;
		end
	endtask

	initial begin
		mode_e m;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		begin_phase(MODE_BGR15, 0, 0);
		push_word(16'h0000, 1'b0);
		push_word(16'hffff, 1'b1);
		push_word(16'h7fff, 1'b0);
		push_word(16'h8000, 1'b1);
		push_word(16'h001f, 1'b0);
		push_word(16'h03e0, 1'b0);
		push_word(16'h7c00, 1'b1);
		push_word(16'h5555, 1'b0);
		push_word(16'haaaa, 1'b1);
		wait_idle();

		begin_phase(MODE_RGB24, 0, 0);
		push_word(16'h2211, 1'b0);
		push_word(16'h4433, 1'b0);
		push_word(16'h6655, 1'b0);
		push_word(16'hffff, 1'b0);
		push_word(16'h00ff, 1'b1);
		push_word(16'h1234, 1'b1);
		push_word(16'h0000, 1'b0);
		push_word(16'hffff, 1'b0);
		push_word(16'hff00, 1'b1);
		push_word(16'habcd, 1'b0);
		wait_idle();

		// hold the partial pixel across mode writes
		write_mode(MODE_BGR15);
		begin_phase(MODE_RGB24, 0, 0);
		push_word(16'h1e0f, 1'b1);
		wait_idle();

		for (int p = 0; p < 8; p++) begin
			m = (p == 1 || p == 5 || p == 7) ? MODE_BGR15 : MODE_RGB24;
			case (p % 4)
				0: begin_phase(m, 0, 0);
				1: begin_phase(m, 55, 0);
				2: begin_phase(m, 0, 55);
				default: begin_phase(m, 12, 12);
			endcase
			if (p == 4)
				hold_len = HOLD_OFF_CYCLES;
			push_random_rows(100);
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (errors == 0 && pending_pixels.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
design/v2r_pkg.sv
design/v2r_convert.sv
design/vram_to_rgb565_repacker.sv
bench/testbench.sv
